// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SOCU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define SOCU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SOCU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SOCU_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: sv/socu_pkg.sv
// Package: types and constants of the sort/unique compactor.
package socu_pkg;

  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned ADDR_W    = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef logic signed [31:0] word_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_e;

  // control of the minimum-select unit
  typedef struct packed {
    logic clear;   // start of a scan pass
    logic sample;  // a read word is present
  } sel_ctl_t;

endpackage

// File: sv/socu_if.sv
// Handshake interfaces for the input and result channels.
interface socu_in_if;
  logic                 valid;
  logic                 ready;
  socu_pkg::word_t      value;
  logic                 last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface socu_out_if;
  logic                 valid;
  logic                 ready;
  socu_pkg::word_t      value_res;
  logic                 last_res;
  logic                 overflow;

  modport source (output valid, output value_res, output last_res, output overflow,
                  input ready);
  modport sink   (input valid, input value_res, input last_res, input overflow,
                  output ready);
endinterface

// File: sv/socu_store.sv
// Element store: one write port, one registered read port.
module socu_store (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  socu_pkg::addr_t wr_addr_i,
  input  socu_pkg::word_t wr_data_i,
  input  logic            rd_en_i,
  input  socu_pkg::addr_t rd_addr_i,
  output socu_pkg::word_t rd_data_o
);
  import socu_pkg::*;

  word_t mem_q [MAX_ITEMS];
  word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/socu_minsel.sv
// Shared compare unit: smallest stored word above the previous result.
module socu_minsel (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  socu_pkg::sel_ctl_t ctl_i,
  input  socu_pkg::word_t    data_i,
  input  socu_pkg::word_t    prev_i,
  input  logic               have_prev_i,
  output logic               found_o,
  output socu_pkg::word_t    best_o
);
  import socu_pkg::*;

  logic  found_q, found_d;
  word_t best_q, best_d;
  logic  above_prev, below_best, take;

  assign above_prev = !have_prev_i || (data_i > prev_i);
  assign below_best = !found_q || (data_i < best_q);
  assign take       = ctl_i.sample && above_prev && below_best;

  always_comb begin
    found_d = found_q;
    best_d  = best_q;
    if (ctl_i.clear) begin
      found_d = 1'b0;
    end else if (take) begin
      found_d = 1'b1;
      best_d  = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
  end

  assign found_o = found_q;
  assign best_o  = best_q;

endmodule

// File: sv/sort_unique_compactor.sv
// Top level: collects a set, then emits its distinct values in ascending order.
//
// Input channel in_i: one signed 32-bit word per handshake; last closes the set
// and belongs to it. Up to MAX_ITEMS words are kept; further words of the set
// are dropped and every result of that set then carries overflow.
// Output channel out_o: one word per distinct value, ascending signed order,
// last_res on the largest one.
// After the closing word the input is not ready until the final result has
// been placed in the output register. Each pass of the shared compare unit
// over the n stored words reads them from the store in turn, then takes a
// drain step and an emit step; k distinct values need k + 1 passes.
// The single store read port and the one comparator make a pass read the
// stored words one by one. A result waits one pass to learn whether it is
// the largest, so the first result reaches the output register from the emit
// step of the second pass.
// A stalled receiver holds the output register; the sequencer waits in its
// emit step and resumes when the register frees. The final result may still
// wait while the next set is loading.
// Reset (asynchronous, active low) empties the set and the output register;
// the store contents are not cleared.
module sort_unique_compactor (
  input  logic       clk_i,
  input  logic       rst_ni,
  socu_in_if.sink    in_i,
  socu_out_if.source out_o
);
  import socu_pkg::*;

  `include "assert_macros.svh"

  localparam cnt_t CAP = cnt_t'(MAX_ITEMS);

  state_e   state_q, state_d;
  cnt_t     count_q, count_d;
  logic     dropped_q, dropped_d;
  addr_t    idx_q, idx_d;
  logic     rd_vld_q;
  word_t    prev_q, prev_d;
  logic     have_prev_q, have_prev_d;
  word_t    pend_q, pend_d;
  logic     pend_vld_q, pend_vld_d;

  // output register
  logic     out_vld_q, out_vld_d;
  word_t    out_value_q, out_value_d;
  logic     out_last_q, out_last_d;
  logic     out_ovf_q, out_ovf_d;

  // sequencer controls
  logic     in_acc, has_room, scan_end, can_push, stall, push;
  logic     wr_en, rd_en;
  sel_ctl_t sel_ctl;
  word_t    rd_data, best;
  logic     found;

  assign in_acc   = in_i.valid && in_i.ready;
  assign has_room = count_q < CAP;
  assign scan_end = {1'b0, idx_q} == (count_q - cnt_t'(1));
  assign can_push = !out_vld_q || out_o.ready;
  assign stall    = pend_vld_q && !can_push;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_acc && in_i.last) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (scan_end) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!stall) state_d = found ? S_SCAN : S_LOAD;
      end
      default: state_d = S_LOAD;
    endcase
  end

  // sequencer outputs; ready is high throughout loading
  always_comb begin
    in_i.ready    = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    push          = 1'b0;
    sel_ctl.clear = 1'b0;
    sel_ctl.sample = rd_vld_q;
    unique case (state_q)
      S_LOAD: begin
        in_i.ready    = 1'b1;
        wr_en         = in_i.valid && has_room;
        sel_ctl.clear = in_i.valid && in_i.last;
      end
      S_SCAN: begin
        rd_en = 1'b1;
      end
      S_DRAIN: begin
      end
      S_EMIT: begin
        push          = pend_vld_q && can_push;
        sel_ctl.clear = !stall && found;
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    count_d     = count_q;
    dropped_d   = dropped_q;
    idx_d       = idx_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    pend_d      = pend_q;
    pend_vld_d  = pend_vld_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (has_room) count_d = count_q + cnt_t'(1);
          else          dropped_d = 1'b1;
          if (in_i.last) begin
            idx_d       = '0;
            have_prev_d = 1'b0;
            pend_vld_d  = 1'b0;
          end
        end
      end
      S_SCAN: begin
        idx_d = idx_q + addr_t'(1);
      end
      S_DRAIN: begin
      end
      S_EMIT: begin
        if (!stall) begin
          if (found) begin
            pend_d      = best;
            pend_vld_d  = 1'b1;
            prev_d      = best;
            have_prev_d = 1'b1;
            idx_d       = '0;
          end else begin
            pend_vld_d = 1'b0;
            count_d    = '0;
            dropped_d  = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register: last_res when no further value was found
  always_comb begin
    out_vld_d   = out_vld_q && !out_o.ready;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    if (push) begin
      out_vld_d   = 1'b1;
      out_value_d = pend_q;
      out_last_d  = !found;
      out_ovf_d   = dropped_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      have_prev_q <= 1'b0;
      pend_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      idx_q       <= idx_d;
      rd_vld_q    <= rd_en;
      have_prev_q <= have_prev_d;
      pend_vld_q  <= pend_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q      <= prev_d;
    pend_q      <= pend_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  socu_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[ADDR_W-1:0]),
    .wr_data_i (in_i.value),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  socu_minsel u_minsel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (sel_ctl),
    .data_i      (rd_data),
    .prev_i      (prev_q),
    .have_prev_i (have_prev_q),
    .found_o     (found),
    .best_o      (best)
  );

  assign out_o.valid     = out_vld_q;
  assign out_o.value_res = out_value_q;
  assign out_o.last_res  = out_last_q;
  assign out_o.overflow  = out_ovf_q;

  // the store never holds more than its capacity
  `SOCU_ASSERT_IMP(a_count_cap, clk_i, rst_ni, 1'b1, count_q <= CAP)
  // a candidate always lies strictly above the previous result
  `SOCU_ASSERT_IMP(a_best_above, clk_i, rst_ni, found && have_prev_q, best > prev_q)
  // read data is only sampled during a scan pass
  `SOCU_ASSERT_IMP(a_rd_in_scan, clk_i, rst_ni, rd_vld_q,
                   state_q == S_SCAN || state_q == S_DRAIN)
  // the final result of a set returns the block to loading
  `SOCU_ASSERT_NXT(a_last_to_load, clk_i, rst_ni, push && !found, state_q == S_LOAD)

endmodule

// File: tb/sort_unique_compactor_tb.sv
// Self-checking testbench for sort_unique_compactor: sets of words in, ascending distinct words out.
module sort_unique_compactor_tb;
  import socu_pkg::*;

  // Settle window after the last result. It covers one full pass over a full store.
  localparam int SETTLE_CYCLES = 300;
  // Bound on the final drain.
  localparam int DRAIN_BOUND   = 40000;
  localparam int RANDOM_WORDS  = 40;
  localparam int REPORT_LIMIT  = 10;

  // One expected result: a distinct word and its flags.
  typedef struct {
    word_t value;
    logic  last;
    logic  overflow;
  } distinct_word_t;

  logic clk_i;
  logic rst_ni;

  socu_in_if  in_if ();
  socu_out_if out_if ();

  sort_unique_compactor u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Model of the block: the words of the open set and its dropped flag.
  word_t          set_words[$];
  logic           set_dropped = 1'b0;
  // Distinct words still owed by the block, oldest first.
  distinct_word_t ascending_q[$];

  int words_sent    = 0;
  int sets_closed   = 0;
  int overflow_sets = 0;
  int results_seen  = 0;
  int error_count   = 0;

  // Sender burst control.
  bit bursty     = 1'b0;
  int burst_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the run.
  initial begin
    #5000000;
    $display("Timeout: %0d distinct words still owed", ascending_q.size());
    $display("Regression FAIL");
    $finish;
  end

  function automatic void note_mismatch(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT)
      $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Takes one accepted word into the model. A closing word sorts the set,
  // drops repeated words and queues the distinct ones.
  function automatic void collect_word(input word_t v, input logic closes);
    word_t          key;
    int             j;
    distinct_word_t r;
    words_sent++;
    // When the store is full, the word is dropped, the closing word too.
    if (set_words.size() < MAX_ITEMS)
      set_words.insert(set_words.size(), v);
    else
      set_dropped = 1'b1;
    if (!closes)
      return;
    // Insertion sort in signed order.
    for (int i = 1; i < set_words.size(); i++) begin
      key = set_words[i];
      j   = i;
      while (j > 0 && key < set_words[j-1]) begin
        set_words[j] = set_words[j-1];
        j--;
      end
      set_words[j] = key;
    end
    // A closed set is never empty. Either the closing word was stored or the store is full.
    for (int i = 0; i < set_words.size(); i++) begin
      if (i == 0 || set_words[i] != set_words[i-1]) begin
        r.value    = set_words[i];
        r.last     = 1'b0;
        r.overflow = set_dropped;
        ascending_q.insert(ascending_q.size(), r);
      end
    end
    ascending_q[ascending_q.size()-1].last = 1'b1;
    sets_closed++;
    if (set_dropped)
      overflow_sets++;
    // The next word starts a fresh set.
    set_words.delete();
    set_dropped = 1'b0;
  endfunction

  // Mix of full-range words, a small pool that forces repeats, and words near the extremes.
  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0:       return word_t'($urandom_range(0, 6)) - 3;
      1:       return word_t'({1'b1, 31'($urandom_range(0, 3))});
      2:       return word_t'(32'h7FFF_FFFF - $urandom_range(0, 3));
      default: return word_t'($urandom);
    endcase
  endfunction

  // Sends one word. It waits for the handshake and then updates the model.
  // valid stays high from one word to the next within a burst.
  task automatic send_word(input word_t v, input logic closes);
    if (bursty && burst_left <= 0) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 6);
    end
    @(negedge clk_i);
    in_if.valid = 1'b1;
    in_if.value = v;
    in_if.last  = closes;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    collect_word(v, closes);
    burst_left--;
  endtask

  // Holds the sender off until every owed result has come.
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    in_if.last  = 1'b0;
    while (ascending_q.size() != 0) @(posedge clk_i);
  endtask

  // Extremes, repeats, a one-word set and an order that needs full sorting.
  task automatic test_directed();
    bursty = 1'b0;
    send_word(word_t'(32'h7FFF_FFFF), 1'b1);
    send_word(word_t'(32'h8000_0000), 1'b1);
    send_word(word_t'(0), 1'b0);
    send_word(word_t'(-1), 1'b0);
    send_word(word_t'(1), 1'b0);
    send_word(word_t'(32'h8000_0000), 1'b0);
    send_word(word_t'(32'h7FFF_FFFF), 1'b0);
    send_word(word_t'(-1), 1'b0);
    send_word(word_t'(0), 1'b1);
    // All words the same. This gives one result.
    repeat (2) send_word(word_t'(5), 1'b0);
    send_word(word_t'(5), 1'b1);
    // Descending input.
    for (int k = 3; k > -1; k--)
      send_word(word_t'(k), 1'b0);
    send_word(word_t'(-1), 1'b1);
    send_word(word_t'(32'h5555_5555), 1'b0);
    send_word(word_t'(32'hAAAA_AAAA), 1'b1);
  endtask

  // A full store with no drop, then a set that overfills and loses its closing word.
  task automatic test_capacity();
    bursty = 1'b1;
    for (int k = 0; k < MAX_ITEMS; k++)
      send_word(word_t'($urandom), k == MAX_ITEMS - 1);
    drain_results();
    for (int k = 0; k <= MAX_ITEMS; k++)
      send_word(word_t'($urandom_range(0, 39)) - 20, k == MAX_ITEMS);
  endtask

  // Random sets. Most are short and a few are near capacity or beyond it.
  // Now and then the sender waits for the results.
  task automatic test_random();
    int base;
    int set_len;
    base   = words_sent;
    bursty = 1'b1;
    while (words_sent - base < RANDOM_WORDS) begin
      set_len = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 68)
                                             : $urandom_range(1, 10);
      for (int k = 0; k < set_len; k++)
        send_word(rand_word(), k == set_len - 1);
      if ($urandom_range(0, 5) == 0)
        drain_results();
    end
  endtask

  // Receiver: a ready pattern that changes now and then. One mode is
  // always ready, and every pattern has at least one ready bit.
  initial begin : ready_pattern
    logic [15:0] pattern;
    int          span;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      case ($urandom_range(0, 3))
        0:       pattern = '1;
        1:       pattern = 16'($urandom & $urandom) | 16'h0001;
        2:       pattern = 16'($urandom) | 16'h0001;
        default: pattern = 16'($urandom | $urandom) | 16'h0001;
      endcase
      span = $urandom_range(20, 120);
      for (int p = 0; p < span; p++) begin
        @(negedge clk_i);
        out_if.ready = pattern[p % 16];
      end
    end
  end

  // Compares each accepted result with the oldest owed distinct word.
  always @(posedge clk_i) begin : result_check
    distinct_word_t exp;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (ascending_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word %0d last %b overflow %b",
                                out_if.value_res, out_if.last_res, out_if.overflow));
      end else begin
        exp = ascending_q.pop_front();
        if (out_if.value_res !== exp.value || out_if.last_res !== exp.last ||
            out_if.overflow !== exp.overflow)
          note_mismatch($sformatf("value exp %0d got %0d, last exp %b got %b, overflow exp %b got %b",
                                  exp.value, out_if.value_res, exp.last, out_if.last_res,
                                  exp.overflow, out_if.overflow));
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.value = '0;
    in_if.last  = 1'b0;
    rst_ni      = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    drain_results();
    test_capacity();
    drain_results();
    test_random();

    // Final drain, with a bound, then a quiet window for any stray result.
    @(negedge clk_i);
    in_if.valid = 1'b0;
    for (int c = 0; c < DRAIN_BOUND && ascending_q.size() != 0; c++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (ascending_q.size() != 0)
      note_mismatch($sformatf("%0d distinct words never arrived", ascending_q.size()));

    $display("Covered %0d sets from %0d words, %0d of them with dropped words.",
             sets_closed, words_sent, overflow_sets);
    $display("Checked %0d results, %0d mismatches.", results_seen, error_count);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
